// File: rtl/gcb_pkg.sv
`timescale 1ns / 1ps
// gcb_pkg: shared widths, constants and the CORDIC angle table of the bearing block.
// No dependencies; used by every other file of the block.
package gcb_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int INT_FRAC        = 24;
   localparam int ITERS           = 30;
   localparam int CORDIC_FRAC     = 30;
   localparam int NUM_LANES       = 3;

   localparam int ZW = 36;
   localparam int RW = 32;
   localparam int VW = 35;

   localparam int LATENCY = 3 + ITERS + 5 + ITERS + 1;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_REF_LON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_LAT = 2'd1;

   localparam logic signed [RW-1:0] K_Q30 = 32'sd652032874;

   localparam logic signed [ZW-1:0] RIGHT_Q24 = 36'sd1509949440;
   localparam logic signed [ZW-1:0] HALF_Q24  = 36'sd3019898880;
   localparam logic signed [ZW-1:0] FULL_Q24  = 36'sd6039797760;

   function automatic logic signed [ZW-1:0] atan_q24(input int step);
      logic signed [ZW-1:0] v;
      case (step)
         0:       v = 36'sd754974720;
         1:       v = 36'sd445687602;
         2:       v = 36'sd235489088;
         3:       v = 36'sd119537938;
         4:       v = 36'sd60000934;
         5:       v = 36'sd30029717;
         6:       v = 36'sd15018523;
         7:       v = 36'sd7509720;
         8:       v = 36'sd3754917;
         9:       v = 36'sd1877466;
         10:      v = 36'sd938734;
         11:      v = 36'sd469367;
         12:      v = 36'sd234683;
         13:      v = 36'sd117342;
         14:      v = 36'sd58671;
         15:      v = 36'sd29335;
         16:      v = 36'sd14668;
         17:      v = 36'sd7334;
         18:      v = 36'sd3667;
         19:      v = 36'sd1833;
         20:      v = 36'sd917;
         21:      v = 36'sd458;
         22:      v = 36'sd229;
         23:      v = 36'sd115;
         24:      v = 36'sd57;
         25:      v = 36'sd29;
         26:      v = 36'sd14;
         27:      v = 36'sd7;
         28:      v = 36'sd4;
         29:      v = 36'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/gcb_rot_cell.sv
`timescale 1ns / 1ps
// gcb_rot_cell: one registered rotation-mode CORDIC step of the sine/cosine chains.
// Depends on gcb_pkg for widths and the angle table.
module gcb_rot_cell #(
   parameter int STEP = 0
) (
   input  logic                           clock,
   input  logic signed [gcb_pkg::RW-1:0]  src_x,
   input  logic signed [gcb_pkg::RW-1:0]  src_y,
   input  logic signed [gcb_pkg::ZW-1:0]  src_z,
   input  logic                           src_flag,
   output logic signed [gcb_pkg::RW-1:0]  dst_x,
   output logic signed [gcb_pkg::RW-1:0]  dst_y,
   output logic signed [gcb_pkg::ZW-1:0]  dst_z,
   output logic                           dst_flag
);

   localparam logic signed [gcb_pkg::ZW-1:0] ANG = gcb_pkg::atan_q24(STEP);

   logic signed [gcb_pkg::RW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [gcb_pkg::ZW-1:0] z_ff, z_in;
   logic                          flag_ff;

   always_comb begin
      if (src_z >= 0) begin
         x_in = src_x - (src_y >>> STEP);
         y_in = src_y + (src_x >>> STEP);
         z_in = src_z - ANG;
      end else begin
         x_in = src_x + (src_y >>> STEP);
         y_in = src_y - (src_x >>> STEP);
         z_in = src_z + ANG;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flag_ff <= src_flag;
   end

   assign dst_x    = x_ff;
   assign dst_y    = y_ff;
   assign dst_z    = z_ff;
   assign dst_flag = flag_ff;

endmodule

// File: rtl/gcb_vec_cell.sv
`timescale 1ns / 1ps
// gcb_vec_cell: one registered vectoring-mode CORDIC step of the arctangent chain.
// Depends on gcb_pkg for widths and the angle table.
module gcb_vec_cell #(
   parameter int STEP = 0
) (
   input  logic                           clock,
   input  logic signed [gcb_pkg::VW-1:0]  src_x,
   input  logic signed [gcb_pkg::VW-1:0]  src_y,
   input  logic signed [gcb_pkg::ZW-1:0]  src_z,
   input  logic                           src_flag,
   output logic signed [gcb_pkg::VW-1:0]  dst_x,
   output logic signed [gcb_pkg::VW-1:0]  dst_y,
   output logic signed [gcb_pkg::ZW-1:0]  dst_z,
   output logic                           dst_flag
);

   localparam logic signed [gcb_pkg::ZW-1:0] ANG = gcb_pkg::atan_q24(STEP);

   logic signed [gcb_pkg::VW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [gcb_pkg::ZW-1:0] z_ff, z_in;
   logic                          flag_ff;

   always_comb begin
      if (src_y > 0) begin
         x_in = src_x + (src_y >>> STEP);
         y_in = src_y - (src_x >>> STEP);
         z_in = src_z + ANG;
      end else begin
         x_in = src_x - (src_y >>> STEP);
         y_in = src_y + (src_x >>> STEP);
         z_in = src_z - ANG;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flag_ff <= src_flag;
   end

   assign dst_x    = x_ff;
   assign dst_y    = y_ff;
   assign dst_z    = z_ff;
   assign dst_flag = flag_ff;

endmodule

// File: rtl/great_circle_bearing_top.sv
`timescale 1ns / 1ps
// great_circle_bearing_top: initial great-circle bearing from the reference point to a target.
// Depends on gcb_pkg, gcb_rot_cell and gcb_vec_cell.
//
// Takes one target per clock (start while busy is low) and returns its heading on rsp_heading
// with a one-cycle rsp_valid strobe; the receiver cannot stall, so results must be taken as
// they appear. The pipeline runs through stages A to C, three parallel 30-cell sine and cosine
// chains, five product and quadrant stages, a 30-cell arctangent chain and stage R. busy is high
// only during reset. Write the reference point through the csr_ port only while no item is in
// flight.
module great_circle_bearing_top #(
   parameter int ANGLE_FRAC_BITS = gcb_pkg::ANGLE_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [ANGLE_FRAC_BITS+8:0]   req_target_lon,
   input  logic signed [ANGLE_FRAC_BITS+7:0]   req_target_lat,
   input  logic                                csr_wr_en,
   input  logic [gcb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ANGLE_FRAC_BITS+8:0]          csr_wr_data,
   output logic                                rsp_valid,
   output logic signed [ANGLE_FRAC_BITS+8:0]   rsp_heading
);

   localparam int LON_W = ANGLE_FRAC_BITS + 9;
   localparam int LAT_W = ANGLE_FRAC_BITS + 8;
   localparam int SH    = gcb_pkg::INT_FRAC - ANGLE_FRAC_BITS;
   localparam int ZW    = gcb_pkg::ZW;
   localparam int RW    = gcb_pkg::RW;
   localparam int VW    = gcb_pkg::VW;
   localparam int NL    = gcb_pkg::NUM_LANES;
   localparam int NI    = gcb_pkg::ITERS;
   localparam int LAT   = gcb_pkg::LATENCY;
   localparam int QF    = gcb_pkg::CORDIC_FRAC;
   localparam logic signed [ZW-1:0] HEAD_LIM = ZW'(180) <<< ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] QUARTER  = gcb_pkg::RIGHT_Q24;

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // configuration
   logic signed [LON_W-1:0] ref_lon_ff, ref_lon_in;
   logic signed [LAT_W-1:0] ref_lat_ff, ref_lat_in;

   always_comb begin
      ref_lon_in = ref_lon_ff;
      ref_lat_in = ref_lat_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            gcb_pkg::REG_REF_LON: ref_lon_in = csr_wr_data;
            gcb_pkg::REG_REF_LAT: ref_lat_in = csr_wr_data[LAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lon_ff <= '0;
         ref_lat_ff <= '0;
      end else begin
         ref_lon_ff <= ref_lon_in;
         ref_lat_ff <= ref_lat_in;
      end
   end

   // transfer tracking
   logic [LAT-1:0] valid_ff, valid_in;
   assign valid_in = {valid_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage A: scale to Q24, longitude difference
   logic signed [ZW-1:0] a_dlon_ff, a_dlon_in, a_lat1_ff, a_lat1_in, a_lat2_ff, a_lat2_in;

   always_comb begin
      a_dlon_in = (ZW'(req_target_lon) <<< SH) - (ZW'(ref_lon_ff) <<< SH);
      a_lat1_in = ZW'(ref_lat_ff) <<< SH;
      a_lat2_in = ZW'(req_target_lat) <<< SH;
   end

   always_ff @(posedge clock) begin
      a_dlon_ff <= a_dlon_in;
      a_lat1_ff <= a_lat1_in;
      a_lat2_ff <= a_lat2_in;
   end

   // stage B: wrap the difference into one turn
   logic signed [ZW-1:0] b_ang_ff [NL];
   logic signed [ZW-1:0] b_ang_in [NL];

   always_comb begin
      if (a_dlon_ff >= gcb_pkg::HALF_Q24) begin
         b_ang_in[0] = a_dlon_ff - gcb_pkg::FULL_Q24;
      end else if (a_dlon_ff < -gcb_pkg::HALF_Q24) begin
         b_ang_in[0] = a_dlon_ff + gcb_pkg::FULL_Q24;
      end else begin
         b_ang_in[0] = a_dlon_ff;
      end
      b_ang_in[1] = a_lat1_ff;
      b_ang_in[2] = a_lat2_ff;
   end

   always_ff @(posedge clock) begin
      b_ang_ff <= b_ang_in;
   end

   // stage C: fold into the right half-plane
   logic signed [ZW-1:0] c_ang_ff [NL];
   logic signed [ZW-1:0] c_ang_in [NL];
   logic [NL-1:0]        c_neg_ff, c_neg_in;

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         if (b_ang_ff[l] > QUARTER) begin
            c_ang_in[l] = b_ang_ff[l] - gcb_pkg::HALF_Q24;
            c_neg_in[l] = 1'b1;
         end else if (b_ang_ff[l] < -QUARTER) begin
            c_ang_in[l] = b_ang_ff[l] + gcb_pkg::HALF_Q24;
            c_neg_in[l] = 1'b1;
         end else begin
            c_ang_in[l] = b_ang_ff[l];
            c_neg_in[l] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ang_ff <= c_ang_in;
      c_neg_ff <= c_neg_in;
   end

   // sine/cosine chains
   logic signed [RW-1:0] rot_x [NL][NI+1];
   logic signed [RW-1:0] rot_y [NL][NI+1];
   logic signed [ZW-1:0] rot_z [NL][NI+1];
   logic                 rot_f [NL][NI+1];

   for (genvar l = 0; l < NL; l++) begin : g_lane
      assign rot_x[l][0] = gcb_pkg::K_Q30;
      assign rot_y[l][0] = '0;
      assign rot_z[l][0] = c_ang_ff[l];
      assign rot_f[l][0] = c_neg_ff[l];
      for (genvar i = 0; i < NI; i++) begin : g_cell
         gcb_rot_cell #(.STEP(i)) u_cell (
            .clock    (clock),
            .src_x    (rot_x[l][i]),
            .src_y    (rot_y[l][i]),
            .src_z    (rot_z[l][i]),
            .src_flag (rot_f[l][i]),
            .dst_x    (rot_x[l][i+1]),
            .dst_y    (rot_y[l][i+1]),
            .dst_z    (rot_z[l][i+1]),
            .dst_flag (rot_f[l][i+1])
         );
      end
   end

   // M0: undo the fold
   logic signed [RW-1:0] m0_s_ff [NL];
   logic signed [RW-1:0] m0_s_in [NL];
   logic signed [RW-1:0] m0_c_ff [NL];
   logic signed [RW-1:0] m0_c_in [NL];

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         m0_s_in[l] = rot_f[l][NI] ? -rot_y[l][NI] : rot_y[l][NI];
         m0_c_in[l] = rot_f[l][NI] ? -rot_x[l][NI] : rot_x[l][NI];
      end
   end

   always_ff @(posedge clock) begin
      m0_s_ff <= m0_s_in;
      m0_c_ff <= m0_c_in;
   end

   // M1: first products
   logic signed [2*RW-1:0] m1_py, m1_p1, m1_p2;
   logic signed [RW-1:0]   m1_y_ff, m1_y_in, m1_p1_ff, m1_p1_in, m1_p2_ff, m1_p2_in;
   logic signed [RW-1:0]   m1_cd_ff;

   always_comb begin
      m1_py    = m0_s_ff[0] * m0_c_ff[2];
      m1_p1    = m0_c_ff[1] * m0_s_ff[2];
      m1_p2    = m0_s_ff[1] * m0_c_ff[2];
      m1_y_in  = RW'(m1_py >>> QF);
      m1_p1_in = RW'(m1_p1 >>> QF);
      m1_p2_in = RW'(m1_p2 >>> QF);
   end

   always_ff @(posedge clock) begin
      m1_y_ff  <= m1_y_in;
      m1_p1_ff <= m1_p1_in;
      m1_p2_ff <= m1_p2_in;
      m1_cd_ff <= m0_c_ff[0];
   end

   // M2: product with cos dLon
   logic signed [2*RW-1:0] m2_pq;
   logic signed [RW-1:0]   m2_q_ff, m2_q_in, m2_y_ff, m2_p1_ff;

   always_comb begin
      m2_pq   = m1_p2_ff * m1_cd_ff;
      m2_q_in = RW'(m2_pq >>> QF);
   end

   always_ff @(posedge clock) begin
      m2_q_ff  <= m2_q_in;
      m2_y_ff  <= m1_y_ff;
      m2_p1_ff <= m1_p1_ff;
   end

   // M3: atan2 terms
   logic signed [VW-1:0] m3_x_ff, m3_x_in, m3_y_ff, m3_y_in;

   always_comb begin
      m3_x_in = VW'(m2_p1_ff) - VW'(m2_q_ff);
      m3_y_in = VW'(m2_y_ff);
   end

   always_ff @(posedge clock) begin
      m3_x_ff <= m3_x_in;
      m3_y_ff <= m3_y_in;
   end

   // P: quadrant pre-turn and zero detect
   logic signed [VW-1:0] p_x_ff, p_x_in, p_y_ff, p_y_in;
   logic signed [ZW-1:0] p_z_ff, p_z_in;
   logic                 p_zero_ff, p_zero_in;

   always_comb begin
      p_zero_in = (m3_x_ff == '0) && (m3_y_ff == '0);
      if (m3_x_ff < 0) begin
         if (m3_y_ff >= 0) begin
            p_x_in = m3_y_ff;
            p_y_in = -m3_x_ff;
            p_z_in = QUARTER;
         end else begin
            p_x_in = -m3_y_ff;
            p_y_in = m3_x_ff;
            p_z_in = -QUARTER;
         end
      end else begin
         p_x_in = m3_x_ff;
         p_y_in = m3_y_ff;
         p_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      p_x_ff    <= p_x_in;
      p_y_ff    <= p_y_in;
      p_z_ff    <= p_z_in;
      p_zero_ff <= p_zero_in;
   end

   // arctangent chain
   logic signed [VW-1:0] vec_x [NI+1];
   logic signed [VW-1:0] vec_y [NI+1];
   logic signed [ZW-1:0] vec_z [NI+1];
   logic                 vec_f [NI+1];

   assign vec_x[0] = p_x_ff;
   assign vec_y[0] = p_y_ff;
   assign vec_z[0] = p_z_ff;
   assign vec_f[0] = p_zero_ff;

   for (genvar i = 0; i < NI; i++) begin : g_vec
      gcb_vec_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .src_x    (vec_x[i]),
         .src_y    (vec_y[i]),
         .src_z    (vec_z[i]),
         .src_flag (vec_f[i]),
         .dst_x    (vec_x[i+1]),
         .dst_y    (vec_y[i+1]),
         .dst_z    (vec_z[i+1]),
         .dst_flag (vec_f[i+1])
      );
   end

   // R: round, saturate, present
   logic signed [ZW-1:0]    r_z, r_round;
   logic signed [LON_W-1:0] heading_ff, heading_in;

   assign r_z = vec_f[NI] ? '0 : vec_z[NI];

   if (SH > 0) begin : g_rnd
      assign r_round = (r_z + (ZW'(1) <<< (SH - 1))) >>> SH;
   end else begin : g_nornd
      assign r_round = r_z;
   end

   always_comb begin
      if (r_round > HEAD_LIM) begin
         heading_in = LON_W'(HEAD_LIM);
      end else if (r_round < -HEAD_LIM) begin
         heading_in = LON_W'(-HEAD_LIM);
      end else begin
         heading_in = LON_W'(r_round);
      end
   end

   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
   end

   assign rsp_valid   = valid_ff[LAT-1];
   assign rsp_heading = heading_ff;

endmodule

// File: rtl/gcb_checker.sv
`timescale 1ns / 1ps
// gcb_checker: port-level timing and range checks for the bearing block, bound to the top.
// Depends on gcb_pkg and great_circle_bearing_top.
module gcb_checker #(
   parameter int ANGLE_FRAC_BITS = gcb_pkg::ANGLE_FRAC_BITS
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic signed [ANGLE_FRAC_BITS+8:0] rsp_heading
);

   localparam int LAT = gcb_pkg::LATENCY;
   localparam logic signed [ANGLE_FRAC_BITS+8:0] LIM = (ANGLE_FRAC_BITS + 9)'(180)
      <<< ANGLE_FRAC_BITS;

   a_transfer_returns: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted item gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching transfer");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading <= LIM) && (rsp_heading >= -LIM))
      else $error("heading out of range");

endmodule

bind great_circle_bearing_top gcb_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_gcb_checker (.*);
